@@ sv/pwm_encoder_capture_decoder_top_defines.svh @@
// Assertion macros used by the capture decoder top.
`ifndef PWM_ENCODER_CAPTURE_DECODER_TOP_DEFINES_SVH
`define PWM_ENCODER_CAPTURE_DECODER_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PECD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pecd assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define PECD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pecd assertion failed");

`endif

@@ sv/pecd_pkg.sv @@
package pecd_pkg;

  // Sizes
  localparam int NUM_CHANNELS = 3;
  localparam int CHAN_W       = 2;
  localparam int TIME_W       = 16;
  localparam int LIMIT_W      = 16;
  localparam int CFG_W        = 16;
  localparam int START_W      = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Register reset values
  localparam logic [TIME_W-1:0]  TIMER_TOP_RST  = 16'd65535;
  localparam logic [CFG_W-1:0]   ROLLOVER_RST   = 16'd2048;
  localparam logic [CFG_W-1:0]   HYST_RST       = 16'd16;
  localparam logic [CFG_W-1:0]   MAX_PULSE_RST  = 16'd65535;
  localparam logic [START_W-1:0] STARTUP_RST    = 4'd10;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMER_TOP      = 3'd0,
    REG_ROLLOVER_THR   = 3'd1,
    REG_BOUND_HYST     = 3'd2,
    REG_MAX_PULSE      = 3'd3,
    REG_STARTUP_EVENTS = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [TIME_W-1:0]  timer_top;
    logic [CFG_W-1:0]   rollover_threshold;
    logic [CFG_W-1:0]   bound_hysteresis;
    logic [CFG_W-1:0]   max_pulse_ticks;
    logic [START_W-1:0] startup_events;
  } cfg_t;

  // Startup countdown reload for all channels
  typedef struct packed {
    logic               load;
    logic [START_W-1:0] value;
  } start_load_t;

  // One capture request as it travels through the queue
  typedef struct packed {
    logic [CHAN_W-1:0]         channel;
    logic [TIME_W-1:0]         capture_time;
    logic signed [LIMIT_W-1:0] lower_limit;
    logic signed [LIMIT_W-1:0] upper_limit;
    logic                      bounds_enable;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ sv/pecd_in_if.sv @@
interface pecd_in_if;
  import pecd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CHAN_W-1:0]         channel;
  logic [TIME_W-1:0]         capture_time;
  logic signed [LIMIT_W-1:0] lower_limit;
  logic signed [LIMIT_W-1:0] upper_limit;
  logic                      bounds_enable;

  modport source (
    output valid, channel, capture_time, lower_limit, upper_limit, bounds_enable,
    input  ready
  );

  modport sink (
    input  valid, channel, capture_time, lower_limit, upper_limit, bounds_enable,
    output ready
  );

endinterface

@@ sv/pecd_out_if.sv @@
interface pecd_out_if;
  import pecd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CHAN_W-1:0]         out_channel;
  logic [TIME_W-1:0]         on_time;
  logic [TIME_W-1:0]         pulse_period;
  logic signed [15:0]        turn_count;
  logic                      below_lower;
  logic                      above_upper;

  modport source (
    output valid, out_channel, on_time, pulse_period, turn_count, below_lower,
           above_upper,
    input  ready
  );

  modport sink (
    input  valid, out_channel, on_time, pulse_period, turn_count, below_lower,
           above_upper,
    output ready
  );

endinterface

@@ sv/pwm_encoder_capture_decoder_top.sv @@
// PWM absolute encoder capture decoder. Each request is one captured edge time
// on one of three channels; each request for a valid channel gives exactly one
// result with that channel's latest on-time, rise-to-rise period, wrapping turn
// count and soft bound flags. Requests for channel 3 are taken and dropped.
// The block takes one request per clock: the front accepts while its two-entry
// queue has room, and the back pops one request per clock while the output
// register is free or being drained and does the whole per-channel
// read-modify-write in that cycle, so edges on the same channel may follow each
// other directly. A result passes through the queue and then the output register,
// which holds it until taken and lets the front keep accepting while it waits.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while
// the block is idle (a rule for the user; the block does not enforce it);
// writing startup_events also reloads every channel's startup countdown.
`include "pwm_encoder_capture_decoder_top_defines.svh"

module pwm_encoder_capture_decoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pecd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pecd_pkg::CFG_W-1:0]      cfg_data_i,
  pecd_in_if.sink                         in_i,
  pecd_out_if.source                      out_o
);
  import pecd_pkg::*;

  localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(NUM_CHANNELS);

  cfg_t        cfg_q;
  start_load_t start_load;
  q_stat_t     q_stat;
  item_t       push_item;
  item_t       pop_item;
  logic        push;
  logic        pop;
  logic        bad_chan;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_top          <= TIMER_TOP_RST;
      cfg_q.rollover_threshold <= ROLLOVER_RST;
      cfg_q.bound_hysteresis   <= HYST_RST;
      cfg_q.max_pulse_ticks    <= MAX_PULSE_RST;
      cfg_q.startup_events     <= STARTUP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TIMER_TOP:      cfg_q.timer_top          <= cfg_data_i;
        REG_ROLLOVER_THR:   cfg_q.rollover_threshold <= cfg_data_i;
        REG_BOUND_HYST:     cfg_q.bound_hysteresis   <= cfg_data_i;
        REG_MAX_PULSE:      cfg_q.max_pulse_ticks    <= cfg_data_i;
        REG_STARTUP_EVENTS: cfg_q.startup_events     <= cfg_data_i[START_W-1:0];
        default: ;
      endcase
    end
  end

  // Reload startup countdowns on a startup_events write
  assign start_load.load  = cfg_we_i && (cfg_idx_i == REG_STARTUP_EVENTS);
  assign start_load.value = cfg_data_i[START_W-1:0];

  pecd_front u_front (
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (push_item)
  );

  pecd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  pecd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_load_i (start_load),
    .q_stat_i     (q_stat),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_o        (out_o)
  );

  // Flag a request for a channel that does not exist
  assign bad_chan = ({1'b0, in_i.channel} >= CHAN_LIMIT);

  // Requests for missing channels never reach the queue
  `PECD_ASSERT_IMP(a_drop_bad_chan, in_i.valid && in_i.ready && bad_chan, !push)
  // Never write into a full queue
  `PECD_ASSERT_IMP(a_no_overflow, push, !q_stat.full)
  // Pop only when the output register can take the result
  `PECD_ASSERT_IMP(a_pop_room, pop, !out_o.valid || out_o.ready)
  // A new result only follows a pop
  `PECD_ASSERT_IMP(a_valid_from_pop, $rose(out_o.valid), $past(pop))

endmodule

@@ sv/pecd_front.sv @@
module pecd_front (
  pecd_in_if.sink          in_i,
  input  pecd_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output pecd_pkg::item_t  item_o
);
  import pecd_pkg::*;

  localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(NUM_CHANNELS);

  logic chan_ok;

  // Take a request whenever the queue has room
  assign in_i.ready = !q_stat_i.full;

  // Drop requests for channels that do not exist
  assign chan_ok = ({1'b0, in_i.channel} < CHAN_LIMIT);
  assign push_o  = in_i.valid && in_i.ready && chan_ok;

  // Pack the request for the queue
  always_comb begin
    item_o.channel       = in_i.channel;
    item_o.capture_time  = in_i.capture_time;
    item_o.lower_limit   = in_i.lower_limit;
    item_o.upper_limit   = in_i.upper_limit;
    item_o.bounds_enable = in_i.bounds_enable;
  end

endmodule

@@ sv/pecd_queue.sv @@
module pecd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pecd_pkg::item_t   item_i,
  input  logic              pop_i,
  output pecd_pkg::item_t   item_o,
  output pecd_pkg::q_stat_t stat_o
);
  import pecd_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ sv/pecd_back.sv @@
module pecd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pecd_pkg::cfg_t        cfg_i,
  input  pecd_pkg::start_load_t start_load_i,
  input  pecd_pkg::q_stat_t     q_stat_i,
  input  pecd_pkg::item_t       item_i,
  output logic                  pop_o,
  pecd_out_if.source            out_o
);
  import pecd_pkg::*;

  // Per-channel state
  logic               first_q    [NUM_CHANNELS];
  logic               expect_q   [NUM_CHANNELS];
  logic [TIME_W-1:0]  rise_q     [NUM_CHANNELS];
  logic [TIME_W-1:0]  fall_q     [NUM_CHANNELS];
  logic [TIME_W-1:0]  high_q     [NUM_CHANNELS];
  logic [TIME_W-1:0]  per_q      [NUM_CHANNELS];
  logic [15:0]        turns_q    [NUM_CHANNELS];
  logic [START_W-1:0] start_q    [NUM_CHANNELS];
  logic               lo_act_q   [NUM_CHANNELS];
  logic               hi_act_q   [NUM_CHANNELS];

  // Output register
  logic               out_valid_q;
  logic [CHAN_W-1:0]  out_chan_q;
  logic [TIME_W-1:0]  out_on_q;
  logic [TIME_W-1:0]  out_per_q;
  logic [15:0]        out_turns_q;
  logic               out_lo_q;
  logic               out_hi_q;

  logic [CHAN_W-1:0]  c;
  logic [TIME_W-1:0]  t;
  logic [TIME_W-1:0]  old_rise, old_fall, old_high;
  logic [TIME_W-1:0]  per_span, on_span;
  logic [TIME_W-1:0]  new_on, new_per;
  logic [TIME_W-1:0]  rise_d, fall_d;
  logic               first_d, expect_d;
  logic [START_W-1:0] start_d;
  logic [15:0]        turns_d;
  logic signed [TIME_W:0] diff;
  logic [TIME_W:0]    mag;
  logic signed [17:0] lo_ext, hi_ext;
  logic [TIME_W-1:0]  lo_eff, hi_eff;
  logic               lo_act_d, hi_act_d;

  // Pop when the output register is free or being drained
  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_o.ready);

  assign c = item_i.channel;
  assign t = item_i.capture_time;

  // Evaluate one edge against the channel state
  always_comb begin
    old_rise = rise_q[c];
    old_fall = fall_q[c];
    old_high = high_q[c];

    // Wrap rule across timer rollover
    if (t > old_rise) begin
      per_span = t - old_rise;
    end else begin
      per_span = cfg_i.timer_top - old_rise + t;
    end
    if (old_rise < old_fall) begin
      on_span = old_fall - old_rise;
    end else begin
      on_span = cfg_i.timer_top - old_rise + old_fall;
    end

    new_on   = old_high;
    new_per  = per_q[c];
    rise_d   = old_rise;
    fall_d   = old_fall;
    first_d  = first_q[c];
    expect_d = expect_q[c];
    if (first_q[c]) begin
      rise_d   = t;
      first_d  = 1'b0;
      expect_d = 1'b0;
    end else if (expect_q[c]) begin
      rise_d   = t;
      expect_d = 1'b0;
      new_per  = per_span;
      new_on   = on_span;
    end else begin
      fall_d   = t;
      expect_d = 1'b1;
    end

    // Turn detection after the startup countdown
    diff    = $signed({1'b0, new_on}) - $signed({1'b0, old_high});
    mag     = diff[TIME_W] ? (TIME_W + 1)'(-diff) : (TIME_W + 1)'(diff);
    start_d = start_q[c];
    turns_d = turns_q[c];
    if (start_q[c] != '0) begin
      start_d = start_q[c] - START_W'(1);
    end else if (mag > {1'b0, cfg_i.rollover_threshold}) begin
      turns_d = diff[TIME_W] ? turns_q[c] + 16'd1 : turns_q[c] - 16'd1;
    end

    // Effective limits with hysteresis, clamped to [0, max_pulse_ticks]
    lo_ext = 18'(item_i.lower_limit)
           + (lo_act_q[c] ? $signed({2'b00, cfg_i.bound_hysteresis}) : 18'sd0);
    hi_ext = 18'(item_i.upper_limit)
           - (hi_act_q[c] ? $signed({2'b00, cfg_i.bound_hysteresis}) : 18'sd0);
    if (lo_ext < 18'sd0) begin
      lo_eff = '0;
    end else if (lo_ext > $signed({2'b00, cfg_i.max_pulse_ticks})) begin
      lo_eff = cfg_i.max_pulse_ticks;
    end else begin
      lo_eff = lo_ext[TIME_W-1:0];
    end
    if (hi_ext < 18'sd0) begin
      hi_eff = '0;
    end else if (hi_ext > $signed({2'b00, cfg_i.max_pulse_ticks})) begin
      hi_eff = cfg_i.max_pulse_ticks;
    end else begin
      hi_eff = hi_ext[TIME_W-1:0];
    end
    lo_act_d = item_i.bounds_enable && (new_on < lo_eff);
    hi_act_d = item_i.bounds_enable && (new_on > hi_eff);
  end

  // Write back the channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        first_q[i]  <= 1'b1;
        expect_q[i] <= 1'b0;
        rise_q[i]   <= '0;
        fall_q[i]   <= '0;
        high_q[i]   <= '0;
        per_q[i]    <= '0;
        turns_q[i]  <= '0;
        start_q[i]  <= STARTUP_RST;
        lo_act_q[i] <= 1'b0;
        hi_act_q[i] <= 1'b0;
      end
    end else if (start_load_i.load) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_q[i] <= start_load_i.value;
      end
    end else if (pop_o) begin
      first_q[c]  <= first_d;
      expect_q[c] <= expect_d;
      rise_q[c]   <= rise_d;
      fall_q[c]   <= fall_d;
      high_q[c]   <= new_on;
      per_q[c]    <= new_per;
      turns_q[c]  <= turns_d;
      start_q[c]  <= start_d;
      lo_act_q[c] <= lo_act_d;
      hi_act_q[c] <= hi_act_d;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_chan_q  <= c;
      out_on_q    <= new_on;
      out_per_q   <= new_per;
      out_turns_q <= turns_d;
      out_lo_q    <= lo_act_d;
      out_hi_q    <= hi_act_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_channel  = out_chan_q;
  assign out_o.on_time      = out_on_q;
  assign out_o.pulse_period = out_per_q;
  assign out_o.turn_count   = $signed(out_turns_q);
  assign out_o.below_lower  = out_lo_q;
  assign out_o.above_upper  = out_hi_q;

endmodule

@@ sim/pecd_decode_checker.sv @@
`timescale 1ns / 1ps

module pecd_decode_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pecd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pecd_pkg::CFG_W-1:0]     cfg_data_i,
  pecd_in_if                             capture_i,
  pecd_out_if                            reading_i,
  output int                             mismatches_o,
  output int                             outstanding_o
);
  import pecd_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [TIME_W-1:0] on_ticks;
    logic [TIME_W-1:0] period_ticks;
    logic [15:0]       turns;
    logic              below;
    logic              above;
  } reading_t;

  // Register copies
  logic [TIME_W-1:0]  timer_top_r;
  logic [CFG_W-1:0]   roll_thr_r;
  logic [CFG_W-1:0]   hyst_r;
  logic [CFG_W-1:0]   max_pulse_r;
  logic [START_W-1:0] startup_r;

  // Per-channel decoder state
  logic               first_pend   [NUM_CHANNELS];
  logic               rise_next    [NUM_CHANNELS];
  logic [TIME_W-1:0]  rise_at      [NUM_CHANNELS];
  logic [TIME_W-1:0]  prev_rise_at [NUM_CHANNELS];
  logic [TIME_W-1:0]  fall_at      [NUM_CHANNELS];
  logic [TIME_W-1:0]  on_ticks     [NUM_CHANNELS];
  logic [TIME_W-1:0]  period_ticks [NUM_CHANNELS];
  logic [15:0]        turn_cnt     [NUM_CHANNELS];
  logic [START_W-1:0] settle_left  [NUM_CHANNELS];
  logic               low_flag     [NUM_CHANNELS];
  logic               high_flag    [NUM_CHANNELS];

  reading_t expected_q[$];
  int       mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  // Ticks from one timer value to a later one, wrapping at the timer top
  function automatic logic [TIME_W-1:0] span(input logic [TIME_W-1:0] from,
                                             input logic [TIME_W-1:0] to);
    if (to > from) return to - from;
    return timer_top_r - from + to;
  endfunction

  function automatic int clamp_limit(input int v);
    if (v < 0) return 0;
    if (v > int'(max_pulse_r)) return int'(max_pulse_r);
    return v;
  endfunction

  task automatic predict_reading(input item_t req);
    int                c;
    int                delta;
    int                lim;
    logic [TIME_W-1:0] on_new;
    logic [TIME_W-1:0] per_new;
    reading_t          r;
    // drop captures for channels that do not exist
    if (req.channel >= NUM_CHANNELS) return;
    c       = req.channel;
    on_new  = on_ticks[c];
    per_new = period_ticks[c];

    // classify the edge: first edge and rises latch the rise time
    if (first_pend[c]) begin
      prev_rise_at[c] = rise_at[c];
      rise_at[c]      = req.capture_time;
      first_pend[c]   = 1'b0;
      rise_next[c]    = 1'b0;
    end else if (rise_next[c]) begin
      prev_rise_at[c] = rise_at[c];
      rise_at[c]      = req.capture_time;
      rise_next[c]    = 1'b0;
      per_new         = span(prev_rise_at[c], rise_at[c]);
      on_new          = span(prev_rise_at[c], fall_at[c]);
    end else begin
      fall_at[c]   = req.capture_time;
      rise_next[c] = 1'b1;
    end

    // count a turn on a large on-time jump once startup has run out
    if (settle_left[c] != 0) begin
      settle_left[c] = settle_left[c] - 1'b1;
    end else begin
      delta = int'(on_new) - int'(on_ticks[c]);
      if ((delta < 0 ? -delta : delta) > int'(roll_thr_r))
        turn_cnt[c] = (delta < 0) ? turn_cnt[c] + 1'b1 : turn_cnt[c] - 1'b1;
    end
    on_ticks[c]     = on_new;
    period_ticks[c] = per_new;

    // widen each limit by the hysteresis while its flag is set
    lim = int'($signed(req.lower_limit));
    if (low_flag[c]) lim = lim + int'(hyst_r);
    lim = clamp_limit(lim);
    low_flag[c] = req.bounds_enable && (int'(on_new) < lim);
    lim = int'($signed(req.upper_limit));
    if (high_flag[c]) lim = lim - int'(hyst_r);
    lim = clamp_limit(lim);
    high_flag[c] = req.bounds_enable && (int'(on_new) > lim);

    r.chan         = req.channel;
    r.on_ticks     = on_new;
    r.period_ticks = per_new;
    r.turns        = turn_cnt[c];
    r.below        = low_flag[c];
    r.above        = high_flag[c];
    expected_q.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
      mismatch_cnt++;
    end
  endtask

  task automatic check_reading();
    reading_t exp_r;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected reading expected none got channel %h on_time %h",
               $time, reading_i.out_channel, reading_i.on_time);
      mismatch_cnt++;
      return;
    end
    exp_r = expected_q.pop_front();
    compare_field("out_channel", 16'(exp_r.chan), 16'(reading_i.out_channel));
    compare_field("on_time", exp_r.on_ticks, reading_i.on_time);
    compare_field("pulse_period", exp_r.period_ticks, reading_i.pulse_period);
    compare_field("turn_count", exp_r.turns, reading_i.turn_count);
    compare_field("below_lower", 16'(exp_r.below), 16'(reading_i.below_lower));
    compare_field("above_upper", 16'(exp_r.above), 16'(reading_i.above_upper));
  endtask

  // Track every accepted request, result and register write
  always @(posedge clk_i or negedge rst_ni) begin : track
    item_t seen;
    if (!rst_ni) begin
      timer_top_r = TIMER_TOP_RST;
      roll_thr_r  = ROLLOVER_RST;
      hyst_r      = HYST_RST;
      max_pulse_r = MAX_PULSE_RST;
      startup_r   = STARTUP_RST;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        first_pend[c]   = 1'b1;
        rise_next[c]    = 1'b0;
        rise_at[c]      = '0;
        prev_rise_at[c] = '0;
        fall_at[c]      = '0;
        on_ticks[c]     = '0;
        period_ticks[c] = '0;
        turn_cnt[c]     = '0;
        settle_left[c]  = STARTUP_RST;
        low_flag[c]     = 1'b0;
        high_flag[c]    = 1'b0;
      end
      expected_q.delete();
      outstanding_o <= 0;
    end else begin
      if (reading_i.valid && reading_i.ready) check_reading();
      if (capture_i.valid && capture_i.ready) begin
        seen.channel       = capture_i.channel;
        seen.capture_time  = capture_i.capture_time;
        seen.lower_limit   = capture_i.lower_limit;
        seen.upper_limit   = capture_i.upper_limit;
        seen.bounds_enable = capture_i.bounds_enable;
        predict_reading(seen);
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_TIMER_TOP:    timer_top_r = cfg_data_i;
          REG_ROLLOVER_THR: roll_thr_r  = cfg_data_i;
          REG_BOUND_HYST:   hyst_r      = cfg_data_i;
          REG_MAX_PULSE:    max_pulse_r = cfg_data_i;
          REG_STARTUP_EVENTS: begin
            // reload every startup countdown with the new value
            startup_r = cfg_data_i[START_W-1:0];
            for (int c = 0; c < NUM_CHANNELS; c++) settle_left[c] = startup_r;
          end
          default: ;
        endcase
      end
      outstanding_o <= expected_q.size();
    end
  end

endmodule

@@ sim/pwm_encoder_capture_decoder_top_test.sv @@
`timescale 1ns / 1ps

module pwm_encoder_capture_decoder_top_test;
  import pecd_pkg::*;

  localparam int QUIET_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int PHASE_ITEMS     = 120;
  localparam int HOLD_OFF_CYCLES = 300;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  cfg_reg_e          cfg_idx;
  logic [CFG_W-1:0]  cfg_data;
  int                mismatches;
  int                outstanding;
  int                quiet_cycles = 0;
  bit                steady = 1'b0;
  bit                hold_off_req = 1'b0;
  logic [TIME_W-1:0] top_now = TIMER_TOP_RST;

  // Per-channel stimulus memory, index 3 is the unused channel
  logic [TIME_W-1:0]         pulse_clock [4] = '{default: '0};
  logic signed [LIMIT_W-1:0] lo_pick     [4] = '{default: '0};
  logic signed [LIMIT_W-1:0] hi_pick     [4] = '{default: 16'sd1000};

  pecd_in_if  capture_ch ();
  pecd_out_if reading_ch ();

  pwm_encoder_capture_decoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (capture_ch),
    .out_o      (reading_ch)
  );

  pecd_decode_checker decode_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .capture_i     (capture_ch),
    .reading_i     (reading_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((capture_ch.valid && capture_ch.ready) || (reading_ch.valid && reading_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pwm_encoder_capture_decoder_top_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int idle_left;
    idle_left = 0;
    reading_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        reading_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (idle_left > 0) begin
        reading_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        reading_ch.ready <= 1'b1;
        if (!steady) idle_left = pick_gap();
      end
    end
  end

  task automatic send_capture(input item_t it);
    int gap;
    capture_ch.valid         <= 1'b1;
    capture_ch.channel       <= it.channel;
    capture_ch.capture_time  <= it.capture_time;
    capture_ch.lower_limit   <= it.lower_limit;
    capture_ch.upper_limit   <= it.upper_limit;
    capture_ch.bounds_enable <= it.bounds_enable;
    do @(posedge clk_i); while (!capture_ch.ready);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      capture_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] t,
                             input logic [LIMIT_W-1:0] lo, input logic [LIMIT_W-1:0] hi,
                             input logic en);
    item_t it;
    it.channel       = ch;
    it.capture_time  = t;
    it.lower_limit   = lo;
    it.upper_limit   = hi;
    it.bounds_enable = en;
    send_capture(it);
  endtask

  // Hold the request side until every reading is back, then let the pipe settle
  task automatic wait_idle();
    capture_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] top, input logic [15:0] thr,
                           input logic [15:0] hyst, input logic [15:0] maxp,
                           input logic [3:0] settle);
    write_reg(REG_TIMER_TOP, top);
    write_reg(REG_ROLLOVER_THR, thr);
    write_reg(REG_BOUND_HYST, hyst);
    write_reg(REG_MAX_PULSE, maxp);
    write_reg(REG_STARTUP_EVENTS, 16'(settle));
    cfg_we <= 1'b0;
    @(posedge clk_i);
    top_now = top;
  endtask

  // Plausible edge trains per channel with some noise and rare bad channels
  task automatic draw_capture(output item_t it);
    logic [CHAN_W-1:0] ch;
    ch = ($urandom_range(0, 19) == 0) ? 2'd3 : CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
    case ($urandom_range(0, 9))
      0:       it.capture_time = 16'($urandom);
      1, 2:    it.capture_time = pulse_clock[ch] + 16'($urandom_range(0, 6000));
      default: it.capture_time = pulse_clock[ch] + 16'($urandom_range(1, 700));
    endcase
    if (top_now != '1 && $urandom_range(0, 9) != 0)
      it.capture_time = 16'(int'(it.capture_time) % (int'(top_now) + 1));
    pulse_clock[ch] = it.capture_time;
    // keep limits sticky so the hysteresis gets exercised
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        lo_pick[ch] = 16'($urandom);
        hi_pick[ch] = 16'($urandom);
      end else begin
        lo_pick[ch] = 16'($urandom_range(0, 3000));
        hi_pick[ch] = 16'($urandom_range(200, 6000));
      end
    end
    it.channel       = ch;
    it.lower_limit   = lo_pick[ch];
    it.upper_limit   = hi_pick[ch];
    it.bounds_enable = ($urandom_range(0, 7) != 0);
  endtask

  task automatic run_random(input int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      draw_capture(it);
      send_capture(it);
      if (i == n / 2) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    rst_ni                   <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_idx                  <= REG_TIMER_TOP;
    cfg_data                 <= '0;
    capture_ch.valid         <= 1'b0;
    capture_ch.channel       <= '0;
    capture_ch.capture_time  <= '0;
    capture_ch.lower_limit   <= '0;
    capture_ch.upper_limit   <= '0;
    capture_ch.bounds_enable <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first edges and the unused channel at reset settings
    send_fields(2'd3, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b1);
    send_fields(2'd3, 16'h0000, 16'h8000, 16'h7FFF, 1'b0);
    send_fields(2'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_fields(2'd1, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1);
    send_fields(2'd2, 16'd1234, 16'd100, 16'd50, 1'b1);
    wait_idle();

    // short timer, no startup: wraps, captures past the top, turns both ways
    configure(16'd1000, 16'd100, 16'd16, 16'd900, 4'd0);
    send_fields(2'd0, 16'd400, 16'd100, 16'd800, 1'b1);
    send_fields(2'd0, 16'd900, 16'd100, 16'd800, 1'b1);
    send_fields(2'd0, 16'd50, 16'd100, 16'd800, 1'b1);
    send_fields(2'd0, 16'd300, 16'd160, 16'd800, 1'b1);
    send_fields(2'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1);
    send_fields(2'd0, 16'd0, 16'h8000, 16'h7FFF, 1'b1);
    send_fields(2'd0, 16'd1000, 16'd0, 16'd0, 1'b1);
    send_fields(2'd0, 16'd1000, 16'd0, 16'd0, 1'b1);
    // lower flag with hysteresis, then cleared by disabling bounds
    send_fields(2'd1, 16'd20, 16'd30, 16'd10, 1'b1);
    send_fields(2'd1, 16'd40, 16'd30, 16'd10, 1'b1);
    send_fields(2'd1, 16'd60, 16'd30, 16'd10, 1'b0);
    send_fields(2'd1, 16'd80, 16'd30, 16'd10, 1'b1);
    send_fields(2'd2, 16'd1300, 16'hFFFB, 16'h7FFF, 1'b1);
    send_fields(2'd3, 16'd500, 16'd0, 16'd0, 1'b1);
    wait_idle();

    // random traffic across register settings, extremes included
    configure(16'd65535, 16'd2048, 16'd16, 16'd65535, 4'd10);
    run_random(PHASE_ITEMS);
    configure(16'd1, 16'd0, 16'd0, 16'd0, 4'd0);
    run_random(PHASE_ITEMS);
    configure(16'd65535, 16'd65535, 16'd65535, 16'd65535, 4'd15);
    run_random(PHASE_ITEMS);

    // back-to-back requests against a long result stall
    configure(16'd5000, 16'd300, 16'd40, 16'd3000, 4'd3);
    steady       = 1'b1;
    hold_off_req = 1'b1;
    run_random(PHASE_ITEMS);
    steady = 1'b0;

    configure(16'($urandom_range(200, 65535)), 16'($urandom_range(0, 4000)),
              16'($urandom_range(0, 300)), 16'($urandom), 4'($urandom_range(0, 15)));
    run_random(PHASE_ITEMS);

    if (mismatches == 0) begin
      $display("pwm_encoder_capture_decoder_top_test: clean");
    end else begin
      $display("pwm_encoder_capture_decoder_top_test: errors");
    end
    $finish;
  end

endmodule
